>>> hdl/tlf_pkg.sv
`default_nettype none
package tlf_pkg;

    // geometry and lane count
    localparam int PLANES      = 4;
    localparam int LANES       = 8;

    // field and datapath widths
    localparam int HIT_W       = 17;
    localparam int Z_W         = 17;
    localparam int SZ_W        = 19;
    localparam int SV_W        = 19;
    localparam int DZ_W        = 20;
    localparam int DV_W        = 20;
    localparam int PROD_W      = 40;
    localparam int Q_W         = 40;
    localparam int P_W         = 43;
    localparam int NUM_W       = 64;
    localparam int DEN_W       = 42;
    localparam int RES_W       = 18;
    localparam int CNT_OUT_W   = 32;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    // iteration counts of the lane sequencer
    localparam int MUL_STEPS   = 20;
    localparam int DIV_STEPS   = 64;

    // histogram range: -448 .. +447 units, 896 = 7 << 7
    localparam int HALF_RANGE  = 448;
    localparam int FULL_RANGE  = 896;
    localparam int RANGE_SHIFT = 7;
    localparam int RECIP7      = 9363;
    localparam int RECIP_SHIFT = 16;

    typedef enum logic {
        CMD_EVENT = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                    valid;
        logic signed [RES_W-1:0] res;
    } lane_stat_t;

    typedef struct packed {
        logic       upd_start;
        logic       rd_start;
        logic [2:0] sel;
    } hist_ctrl_t;

    typedef struct packed {
        logic                 clearing;
        logic                 done;
        logic [CNT_OUT_W-1:0] count;
    } hist_stat_t;

endpackage
`default_nettype wire

>>> hdl/track_line_fit_residual_histogram.sv
// Event: accept is followed by the fit setup, the lane run
// (20 shift-add multiply steps and 64 restoring divide steps) and the histogram update.
// Read: the count comes from the registered read of the histogram RAM.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset clears the plane registers and sweeps all 8*(HIST_BINS+2) counters to zero,
// one per cycle (3216 counters at default); in_stall stays high during the sweep.
`default_nettype none
module track_line_fit_residual_histogram #(
    parameter int HIST_BINS   = 400,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tlf_pkg::PADDR_W-1:0]          paddr,
    input  logic [tlf_pkg::PDATA_W-1:0]          pwdata,
    output logic [tlf_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_x1,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_y1,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_x2,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_y2,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_x3,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_y3,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_x4,
    input  logic signed [tlf_pkg::HIT_W-1:0]     hit_y4,
    input  logic [2:0]                           hist_select,
    input  logic [$clog2(HIST_BINS+2)-1:0]       bin_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tlf_pkg::RES_W-1:0]     res_x1,
    output logic signed [tlf_pkg::RES_W-1:0]     res_y1,
    output logic signed [tlf_pkg::RES_W-1:0]     res_x2,
    output logic signed [tlf_pkg::RES_W-1:0]     res_y2,
    output logic signed [tlf_pkg::RES_W-1:0]     res_x3,
    output logic signed [tlf_pkg::RES_W-1:0]     res_y3,
    output logic signed [tlf_pkg::RES_W-1:0]     res_x4,
    output logic signed [tlf_pkg::RES_W-1:0]     res_y4,
    output logic [tlf_pkg::CNT_OUT_W-1:0]        bin_count
);
    import tlf_pkg::*;

    localparam int SLOT_W = $clog2(HIST_BINS + 2);

    typedef enum logic [3:0] {
        T_IDLE,
        T_FIT0,
        T_FIT1,
        T_FIT2,
        T_START,
        T_LANE,
        T_HIST,
        T_RDSTART,
        T_READ,
        T_DONE
    } tstate_t;

    tstate_t state_reg, state_next;
    logic    out_valid_reg, out_valid_next;

    logic [Z_W-1:0]           z_reg [PLANES];
    logic                     cmd_reg;
    logic signed [HIT_W-1:0]  hx_reg [PLANES];
    logic signed [HIT_W-1:0]  hy_reg [PLANES];
    logic [2:0]               sel_reg;
    logic [SLOT_W-1:0]        bin_reg;
    logic signed [DZ_W-1:0]   dz_reg [PLANES];
    logic signed [DV_W-1:0]   dvx_reg [PLANES];
    logic signed [DV_W-1:0]   dvy_reg [PLANES];
    logic signed [PROD_W-1:0] sq_reg [PLANES];
    logic signed [PROD_W-1:0] px_reg [PLANES];
    logic signed [PROD_W-1:0] py_reg [PLANES];
    logic [Q_W-1:0]           q_reg;
    logic signed [P_W-1:0]    pxs_reg, pys_reg;
    logic signed [RES_W-1:0]  res_out_reg [LANES];
    logic [CNT_OUT_W-1:0]     cnt_out_reg;

    logic                     cfg_we, accept, out_free, all_valid, lane_start;
    logic [SZ_W-1:0]          sz;
    logic signed [SV_W-1:0]   sx, sy;
    lane_stat_t               lane_stat [LANES];
    logic [SLOT_W-1:0]        lane_slot [LANES];
    logic [LANES-1:0]         lane_valid;
    hist_ctrl_t               hist_ctrl;
    hist_stat_t               hist_stat;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = PDATA_W'(z_reg[paddr[3:2]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANES; i++)
            begin
                z_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            z_reg[paddr[3:2]] <= pwdata[Z_W-1:0];
        end
    end

    // handshake
    assign in_stall  = (state_reg != T_IDLE) || hist_stat.clearing;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // sums over the planes
    always_comb
    begin
        sz = '0;
        sx = '0;
        sy = '0;
        for (int i = 0; i < PLANES; i++)
        begin
            sz = sz + SZ_W'(z_reg[i]);
            sx = sx + SV_W'(hx_reg[i]);
            sy = sy + SV_W'(hy_reg[i]);
        end
    end

    // lanes: one per plane and axis, histogram index 2*plane + axis
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        tlf_lane #(
            .HIST_BINS(HIST_BINS)
        ) u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .start(lane_start),
            .dz   (dz_reg[j / 2]),
            .dv   ((j % 2 == 1) ? dvy_reg[j / 2] : dvx_reg[j / 2]),
            .q    (q_reg),
            .p    ((j % 2 == 1) ? pys_reg : pxs_reg),
            .stat (lane_stat[j]),
            .slot (lane_slot[j])
        );
        assign lane_valid[j] = lane_stat[j].valid;
    end

    assign all_valid  = &lane_valid;
    assign lane_start = (state_reg == T_START);

    assign hist_ctrl.upd_start = (state_reg == T_LANE) && all_valid;
    assign hist_ctrl.rd_start  = (state_reg == T_RDSTART);
    assign hist_ctrl.sel       = sel_reg;

    tlf_hist #(
        .HIST_BINS  (HIST_BINS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_hist (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (hist_ctrl),
        .bin  (bin_reg),
        .slots(lane_slot),
        .stat (hist_stat)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == CMD_READ) ? T_RDSTART : T_FIT0;
                end
            end
            T_FIT0:    state_next = T_FIT1;
            T_FIT1:    state_next = T_FIT2;
            T_FIT2:    state_next = T_START;
            T_START:   state_next = T_LANE;
            T_LANE:
            begin
                if (all_valid)
                begin
                    state_next = T_HIST;
                end
            end
            T_HIST:
            begin
                if (hist_stat.done)
                begin
                    state_next = T_DONE;
                end
            end
            T_RDSTART: state_next = T_READ;
            T_READ:
            begin
                if (hist_stat.done)
                begin
                    state_next = T_DONE;
                end
            end
            T_DONE:
            begin
                if (out_free)
                begin
                    state_next     = T_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the beat and run the fit setup
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            hx_reg[0] <= hit_x1;
            hx_reg[1] <= hit_x2;
            hx_reg[2] <= hit_x3;
            hx_reg[3] <= hit_x4;
            hy_reg[0] <= hit_y1;
            hy_reg[1] <= hit_y2;
            hy_reg[2] <= hit_y3;
            hy_reg[3] <= hit_y4;
            sel_reg   <= hist_select;
            bin_reg   <= bin_index;
        end
        if (state_reg == T_FIT0)
        begin
            for (int i = 0; i < PLANES; i++)
            begin
                dz_reg[i]  <= DZ_W'({2'b00, z_reg[i], 2'b00} - {2'b00, sz});
                dvx_reg[i] <= DV_W'((DV_W + 1)'($signed({hx_reg[i], 2'b00}))
                                    - (DV_W + 1)'(sx));
                dvy_reg[i] <= DV_W'((DV_W + 1)'($signed({hy_reg[i], 2'b00}))
                                    - (DV_W + 1)'(sy));
            end
        end
        if (state_reg == T_FIT1)
        begin
            for (int i = 0; i < PLANES; i++)
            begin
                sq_reg[i] <= dz_reg[i] * dz_reg[i];
                px_reg[i] <= dz_reg[i] * dvx_reg[i];
                py_reg[i] <= dz_reg[i] * dvy_reg[i];
            end
        end
        if (state_reg == T_FIT2)
        begin
            q_reg   <= Q_W'($unsigned(sq_reg[0])) + Q_W'($unsigned(sq_reg[1]))
                     + Q_W'($unsigned(sq_reg[2])) + Q_W'($unsigned(sq_reg[3]));
            pxs_reg <= P_W'(px_reg[0]) + P_W'(px_reg[1]) + P_W'(px_reg[2]) + P_W'(px_reg[3]);
            pys_reg <= P_W'(py_reg[0]) + P_W'(py_reg[1]) + P_W'(py_reg[2]) + P_W'(py_reg[3]);
        end
        // load the output register
        if (state_reg == T_DONE && out_free)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                res_out_reg[j] <= (cmd_reg == CMD_READ) ? '0 : lane_stat[j].res;
            end
            cnt_out_reg <= (cmd_reg == CMD_READ) ? hist_stat.count : '0;
        end
    end

    assign res_x1    = res_out_reg[0];
    assign res_y1    = res_out_reg[1];
    assign res_x2    = res_out_reg[2];
    assign res_y2    = res_out_reg[3];
    assign res_x3    = res_out_reg[4];
    assign res_y3    = res_out_reg[5];
    assign res_x4    = res_out_reg[6];
    assign res_y4    = res_out_reg[7];
    assign bin_count = cnt_out_reg;

endmodule
`default_nettype wire

>>> hdl/tlf_ram.sv
`default_nettype none
module tlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/tlf_lane.sv
`default_nettype none
module tlf_lane #(
    parameter int HIST_BINS = 400
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [tlf_pkg::DZ_W-1:0]      dz,
    input  logic signed [tlf_pkg::DV_W-1:0]      dv,
    input  logic [tlf_pkg::Q_W-1:0]              q,
    input  logic signed [tlf_pkg::P_W-1:0]       p,
    output tlf_pkg::lane_stat_t                  stat,
    output logic [$clog2(HIST_BINS+2)-1:0]       slot
);
    import tlf_pkg::*;

    localparam int SLOT_W = $clog2(HIST_BINS + 2);
    localparam int CNT_W  = $clog2(DIV_STEPS);
    localparam int T_W    = $clog2(FULL_RANGE);
    localparam int HB_W   = $clog2(HIST_BINS + 1);
    localparam int BP_W   = T_W + HB_W;
    localparam int U_W    = BP_W - RANGE_SHIFT;
    localparam int R_W    = $clog2(RECIP7 + 1);
    localparam int QD_W   = U_W + R_W;

    localparam logic [RES_W-1:0] RES_MAX_V = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN_V = {1'b1, {(RES_W-1){1'b0}}};

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_SETUP,
        L_DIV,
        L_FIN,
        L_BIN0,
        L_BIN1,
        L_BIN2
    } lstate_t;

    lstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               valid_reg, valid_next;

    logic [NUM_W-1:0]        mcand_a_reg, mcand_b_reg;
    logic [DZ_W-1:0]         mlt_a_reg;
    logic [DV_W-1:0]         mlt_b_reg;
    logic [NUM_W-1:0]        acc_a_reg, acc_b_reg;
    logic signed [DV_W-1:0]  dv_reg;
    logic                    qzero_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    neg_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic signed [RES_W-1:0] res_reg;
    logic                    uflow_reg, oflow_reg;
    logic [BP_W-1:0]         bprod_reg;
    logic [QD_W-1:0]         qd_reg;
    logic [SLOT_W-1:0]       slot_reg;

    logic                    last_mul, last_div;
    logic [NUM_W-1:0]        term_a, term_b, add_a, add_b;
    logic [NUM_W-1:0]        num, mag;
    logic [DEN_W:0]          trial;
    logic                    ge;
    logic [DEN_W:0]          trial_sub;
    logic                    big_pos, big_neg;
    logic [RES_W:0]          res_sum;
    logic [T_W-1:0]          tidx;
    logic [U_W-1:0]          ushift;
    logic [QD_W-1:0]         qv;

    // one shift-add step for both products
    always_comb
    begin
        last_mul = (cnt_reg == CNT_W'(MUL_STEPS - 1));
        last_div = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        term_a   = mlt_a_reg[0] ? mcand_a_reg : '0;
        term_b   = mlt_b_reg[0] ? mcand_b_reg : '0;
        add_a    = last_mul ? acc_a_reg - term_a : acc_a_reg + term_a;
        add_b    = last_mul ? acc_b_reg - term_b : acc_b_reg + term_b;
    end

    // numerator magnitude and one restoring division step
    always_comb
    begin
        num       = qzero_reg ? NUM_W'(0) - NUM_W'(dv_reg) : acc_a_reg - acc_b_reg;
        mag       = num[NUM_W-1] ? NUM_W'(0) - num : num;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
        big_pos   = (quo_reg > NUM_W'(2 ** (RES_W - 1) - 1));
        big_neg   = (quo_reg > NUM_W'(2 ** (RES_W - 1)));
        res_sum   = {res_reg[RES_W-1], res_reg} + (RES_W + 1)'(HALF_RANGE);
        tidx      = res_sum[T_W-1:0];
        ushift    = U_W'(bprod_reg >> RANGE_SHIFT);
        qv        = qd_reg >> RECIP_SHIFT;
    end

    // sequence the multiply, divide and binning steps
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    state_next = L_MUL;
                    cnt_next   = '0;
                    valid_next = 1'b0;
                end
            end
            L_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_mul)
                begin
                    state_next = L_SETUP;
                end
            end
            L_SETUP:
            begin
                state_next = L_DIV;
                cnt_next   = '0;
            end
            L_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_div)
                begin
                    state_next = L_FIN;
                end
            end
            L_FIN:  state_next = L_BIN0;
            L_BIN0: state_next = L_BIN1;
            L_BIN1: state_next = L_BIN2;
            L_BIN2:
            begin
                state_next = L_IDLE;
                valid_next = 1'b1;
            end
            default: state_next = L_IDLE;
        endcase
        if (start && state_reg != L_IDLE)
        begin
            state_next = L_MUL;
            cnt_next   = '0;
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_a_reg <= NUM_W'(p);
            mcand_b_reg <= NUM_W'(q);
            mlt_a_reg   <= dz;
            mlt_b_reg   <= dv;
            acc_a_reg   <= '0;
            acc_b_reg   <= '0;
            dv_reg      <= dv;
            qzero_reg   <= (q == '0);
            den_reg     <= (q == '0) ? DEN_W'(4) : {q, 2'b00};
        end
        else
        begin
            case (state_reg)
                L_MUL:
                begin
                    mcand_a_reg <= mcand_a_reg << 1;
                    mcand_b_reg <= mcand_b_reg << 1;
                    mlt_a_reg   <= mlt_a_reg >> 1;
                    mlt_b_reg   <= mlt_b_reg >> 1;
                    acc_a_reg   <= add_a;
                    acc_b_reg   <= add_b;
                end
                L_SETUP:
                begin
                    neg_reg <= num[NUM_W-1];
                    quo_reg <= mag + NUM_W'(den_reg >> 1);
                    rem_reg <= '0;
                end
                L_DIV:
                begin
                    rem_reg <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], ge};
                end
                L_FIN:
                begin
                    if (neg_reg)
                    begin
                        res_reg <= big_neg ? RES_MIN_V : RES_W'(0) - quo_reg[RES_W-1:0];
                    end
                    else
                    begin
                        res_reg <= big_pos ? RES_MAX_V : quo_reg[RES_W-1:0];
                    end
                end
                L_BIN0:
                begin
                    uflow_reg <= (res_reg < -RES_W'(HALF_RANGE));
                    oflow_reg <= (res_reg >= RES_W'(HALF_RANGE));
                    bprod_reg <= BP_W'(tidx) * BP_W'(HIST_BINS);
                end
                L_BIN1:
                begin
                    qd_reg <= QD_W'(ushift) * QD_W'(RECIP7);
                end
                L_BIN2:
                begin
                    if (uflow_reg)
                    begin
                        slot_reg <= '0;
                    end
                    else if (oflow_reg)
                    begin
                        slot_reg <= SLOT_W'(HIST_BINS + 1);
                    end
                    else
                    begin
                        slot_reg <= SLOT_W'(qv) + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.valid = valid_reg;
    assign stat.res   = res_reg;
    assign slot       = slot_reg;

endmodule
`default_nettype wire

>>> hdl/tlf_hist.sv
`default_nettype none
module tlf_hist #(
    parameter int HIST_BINS   = 400,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlf_pkg::hist_ctrl_t              ctrl,
    input  logic [$clog2(HIST_BINS+2)-1:0]   bin,
    input  logic [$clog2(HIST_BINS+2)-1:0]   slots [tlf_pkg::LANES],
    output tlf_pkg::hist_stat_t              stat
);
    import tlf_pkg::*;

    localparam int SLOT_W = $clog2(HIST_BINS + 2);
    localparam int SLOTS  = HIST_BINS + 2;
    localparam int DEPTH  = LANES * SLOTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(LANES);
    localparam int EXT_W  = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        H_CLEAR,
        H_IDLE,
        H_RD,
        H_WR,
        H_RDCMD,
        H_RDOUT
    } hstate_t;

    hstate_t              state_reg;
    logic [AW-1:0]        addr_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [2:0]           sel_reg;
    logic [SLOT_W-1:0]    bin_reg;
    logic                 done_reg;
    logic [CNT_OUT_W-1:0] count_reg;

    logic                   we;
    logic [AW-1:0]          waddr, raddr, upd_addr, rd_addr;
    logic [COUNT_WIDTH-1:0] wdata, rdata;
    logic [EXT_W-1:0]       rd_ext;
    logic [CNT_OUT_W-1:0]   rd_cap;

    // address of the counter that a lane's slot hits, and of a read
    always_comb
    begin
        upd_addr = AW'(idx_reg) * AW'(SLOTS) + AW'(slots[idx_reg]);
        rd_addr  = AW'(sel_reg) * AW'(SLOTS) + AW'(bin_reg);
        raddr    = (state_reg == H_RDCMD) ? rd_addr : upd_addr;
        rd_ext   = EXT_W'(rdata);
        rd_cap   = (rd_ext > EXT_W'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
                                                        : rd_ext[CNT_OUT_W-1:0];
    end

    // write a zero while clearing, a saturating increment while updating
    always_comb
    begin
        we    = 1'b0;
        waddr = upd_addr;
        wdata = (rdata == CNT_MAX) ? rdata : rdata + 1'b1;
        case (state_reg)
            H_CLEAR:
            begin
                we    = 1'b1;
                waddr = addr_reg;
                wdata = '0;
            end
            H_WR:    we = 1'b1;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_CLEAR;
            addr_reg  <= '0;
            idx_reg   <= '0;
            sel_reg   <= '0;
            bin_reg   <= '0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= H_IDLE;
                    end
                end
                H_IDLE:
                begin
                    idx_reg <= '0;
                    if (ctrl.upd_start)
                    begin
                        state_reg <= H_RD;
                    end
                    else if (ctrl.rd_start)
                    begin
                        sel_reg   <= ctrl.sel;
                        bin_reg   <= bin;
                        state_reg <= H_RDCMD;
                    end
                end
                H_RD: state_reg <= H_WR;
                H_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(LANES - 1))
                    begin
                        state_reg <= H_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= H_RD;
                    end
                end
                H_RDCMD: state_reg <= H_RDOUT;
                H_RDOUT:
                begin
                    count_reg <= (32'(bin_reg) < 32'(SLOTS)) ? rd_cap : '0;
                    done_reg  <= 1'b1;
                    state_reg <= H_IDLE;
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    tlf_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign stat.clearing = (state_reg == H_CLEAR);
    assign stat.done     = done_reg;
    assign stat.count    = count_reg;

endmodule
`default_nettype wire

>>> hdl/tlf_check.sv
`default_nettype none
module tlf_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [tlf_pkg::RES_W-1:0]  res_x1,
    input logic [tlf_pkg::CNT_OUT_W-1:0]     bin_count
);

    // one item at a time: an accepted beat closes the input
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(bin_count) && $stable(res_x1))
        else $error("stalled result changed");

    // an event beat carries no bin count
    a_event_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_x1 != '0 |-> bin_count == '0)
        else $error("event result with nonzero bin count");

endmodule

bind track_line_fit_residual_histogram tlf_check u_check (.*);
`default_nettype wire
